// ===== sv/spq_pkg.sv =====
// ============================================================================
// Sorted priority queue package
// Shared status codes, operation codes and the cell control group.
// ============================================================================
package spq_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    // Operation codes carried in the input tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic ins;  // place the new entry, shifting lower entries toward the tail
        logic srv;  // drop the head, shifting every entry toward the head
    } spq_ctrl_t;

endpackage

// ===== sv/sorted_priority_queue_top.sv =====
// A result is registered and leaves on m_* in the cycle after its request is accepted.
// Throughput: one request per cycle while m_tready takes each result; all cells update on the same edge.
// The input stays open while a result waits, as long as m_tready takes it then.
// Reset (aresetn low, synchronous) clears the fill count and the output valid.
// Slot contents are not reset; only slots below the fill count are ever read.
// ============================================================================
// Sorted priority queue top level
// A chain of CAPACITY cells kept sorted by priority, highest at the head.
// Insert places an entry behind all entries of equal or higher priority;
// serve returns and removes the head entry.
// ============================================================================
module sorted_priority_queue_top #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int HANDLE_BITS   = 16,
    localparam int CNT_BITS     = $clog2(CAPACITY + 1),
    localparam int IN_W         = ((PRIORITY_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_W        = ((HANDLE_BITS + PRIORITY_BITS + CNT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // entry_priority, entry_handle, zero fill
    input  logic [0:0]       s_tuser,   // operation
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // served_handle, served_priority, occupancy, zero fill
    output logic [1:0]       m_tuser    // status
);

    localparam int PB = PRIORITY_BITS;
    localparam int HB = HANDLE_BITS;

    logic [PB-1:0] in_prio;
    logic [HB-1:0] in_handle;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          do_ins;
    logic          do_srv;
    spq_pkg::spq_ctrl_t ctrl;

    logic [PB-1:0] cell_prio   [CAPACITY];
    logic [HB-1:0] cell_handle [CAPACITY];
    logic          cell_lower  [CAPACITY];

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    spq_pkg::spq_status_t status_reg;
    spq_pkg::spq_status_t status_next;
    logic [HB-1:0]       out_handle_reg;
    logic [HB-1:0]       out_handle_next;
    logic [PB-1:0]       out_prio_reg;
    logic [PB-1:0]       out_prio_next;
    logic [CNT_BITS-1:0] out_count_reg;

    // Input transaction unpacking and handshake.
    assign in_prio   = s_tdata[PB-1:0];
    assign in_handle = s_tdata[PB+HB-1:PB];
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign is_full  = (count_reg == CNT_BITS'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign do_ins   = accept && (s_tuser[0] == spq_pkg::OP_INSERT) && !is_full;
    assign do_srv   = accept && (s_tuser[0] == spq_pkg::OP_SERVE) && !is_empty;
    assign ctrl.ins = do_ins;
    assign ctrl.srv = do_srv;

    // The chain of cells; each trades entries with its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic          prev_lower;
        logic [PB-1:0] prev_prio;
        logic [HB-1:0] prev_handle;
        logic [PB-1:0] next_prio;
        logic [HB-1:0] next_handle;

        if (i == 0) begin : g_head
            assign prev_lower  = 1'b0;
            assign prev_prio   = '0;
            assign prev_handle = '0;
        end else begin : g_body
            assign prev_lower  = cell_lower[i-1];
            assign prev_prio   = cell_prio[i-1];
            assign prev_handle = cell_handle[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_prio   = '0;
            assign next_handle = '0;
        end else begin : g_link
            assign next_prio   = cell_prio[i+1];
            assign next_handle = cell_handle[i+1];
        end

        spq_cell #(
            .PB (PB),
            .HB (HB)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (count_reg > CNT_BITS'(i)),
            .new_prio    (in_prio),
            .new_handle  (in_handle),
            .prev_lower  (prev_lower),
            .prev_prio   (prev_prio),
            .prev_handle (prev_handle),
            .next_prio   (next_prio),
            .next_handle (next_handle),
            .lower       (cell_lower[i]),
            .prio        (cell_prio[i]),
            .handle      (cell_handle[i])
        );
    end

    // Next fill count and result fields.
    always_comb begin
        count_next      = count_reg;
        status_next     = status_reg;
        out_handle_next = out_handle_reg;
        out_prio_next   = out_prio_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        if (accept) begin
            m_valid_next    = 1'b1;
            out_handle_next = '0;
            out_prio_next   = '0;
            if (s_tuser[0] == spq_pkg::OP_INSERT) begin
                if (is_full) begin
                    status_next = spq_pkg::ST_FULL;
                end else begin
                    status_next = spq_pkg::ST_INSERTED;
                    count_next  = count_reg + CNT_BITS'(1);
                end
            end else begin
                if (is_empty) begin
                    status_next = spq_pkg::ST_EMPTY;
                end else begin
                    status_next     = spq_pkg::ST_SERVED;
                    out_handle_next = cell_handle[0];
                    out_prio_next   = cell_prio[0];
                    count_next      = count_reg - CNT_BITS'(1);
                end
            end
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded on each accepted transaction.
    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        out_handle_reg <= out_handle_next;
        out_prio_reg   <= out_prio_next;
        if (accept) begin
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({out_count_reg, out_prio_reg, out_handle_reg});

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("fill count exceeds capacity");

    // The two entries at the head stay in order.
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_BITS'(2)) |-> (cell_prio[0] >= cell_prio[1]))
        else $error("head entries out of priority order");

    // An insert into a full queue is reported and leaves the count alone.
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser[0] == spq_pkg::OP_INSERT) && is_full)
        |=> (m_tvalid && (m_tuser == spq_pkg::ST_FULL) && $stable(count_reg)))
        else $error("insert into full queue not rejected");

    // A serve on an empty queue is reported as empty.
    a_empty_serve: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser[0] == spq_pkg::OP_SERVE) && is_empty)
        |=> (m_tvalid && (m_tuser == spq_pkg::ST_EMPTY) && (count_reg == '0)))
        else $error("serve on empty queue not reported");

endmodule

// ===== sv/spq_cell.sv =====
// ============================================================================
// Sorted priority queue cell
// One slot of the sorted chain. It compares its entry against the new one and
// trades entries with its neighbors on insert and serve.
// ============================================================================
module spq_cell #(
    parameter int PB = 8,
    parameter int HB = 16
) (
    input  logic              aclk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic              occupied,     // this slot holds a valid entry
    input  logic [PB-1:0]     new_prio,
    input  logic [HB-1:0]     new_handle,
    input  logic              prev_lower,   // the slot toward the head yields its place
    input  logic [PB-1:0]     prev_prio,
    input  logic [HB-1:0]     prev_handle,
    input  logic [PB-1:0]     next_prio,
    input  logic [HB-1:0]     next_handle,
    output logic              lower,        // new entry goes at or ahead of this slot
    output logic [PB-1:0]     prio,
    output logic [HB-1:0]     handle
);

    logic [PB-1:0] prio_reg;
    logic [PB-1:0] prio_next;
    logic [HB-1:0] handle_reg;
    logic [HB-1:0] handle_next;

    // An empty slot or a strictly lower priority yields to the new entry,
    // so equal priorities keep their arrival order.
    assign lower = !occupied || (prio_reg < new_prio);

    // Choose what this slot holds after the transaction.
    always_comb begin
        prio_next   = prio_reg;
        handle_next = handle_reg;
        if (ctrl.ins) begin
            if (prev_lower) begin
                prio_next   = prev_prio;
                handle_next = prev_handle;
            end else if (lower) begin
                prio_next   = new_prio;
                handle_next = new_handle;
            end
        end else if (ctrl.srv) begin
            prio_next   = next_prio;
            handle_next = next_handle;
        end
    end

    // Slot contents need no reset; the fill count marks which are valid.
    always_ff @(posedge aclk) begin
        prio_reg   <= prio_next;
        handle_reg <= handle_next;
    end

    assign prio   = prio_reg;
    assign handle = handle_reg;

endmodule
